@@ sv/hdut_pkg.sv @@
`default_nettype none
package hdut_pkg;

   localparam int TX_DEPTH = 512;
   localparam int GAP_BITS = 8;

   localparam int TX_AW  = $clog2(TX_DEPTH);
   localparam int TX_CW  = $clog2(TX_DEPTH + 1);
   localparam int TMR_W  = 24;
   localparam int GAP_TW = 16 + $clog2(GAP_BITS + 1);

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_LOAD  = 2'd1;
   localparam logic [1:0] REQ_START = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TIMEOUT = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;

   localparam logic [1:0] CSR_BIT_TIME   = 2'd0;
   localparam logic [1:0] CSR_HALF_BIT   = 2'd1;
   localparam logic [1:0] CSR_RX_TIMEOUT = 2'd2;

   localparam logic [15:0]      BIT_TIME_RST   = 16'd52;
   localparam logic [15:0]      HALF_BIT_RST   = 16'd26;
   localparam logic [TMR_W-1:0] RX_TIMEOUT_RST = 24'd100000;

   typedef struct packed {
      logic [1:0] req_type;
      logic       line_in;
      logic [7:0] tx_byte;
      logic [7:0] rx_len;
   } hdut_req_type;

   typedef struct packed {
      logic       line_out;
      logic       line_drive;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] rx_received;
      logic       busy_res;
   } hdut_rsp_type;

endpackage
`default_nettype wire

@@ sv/half_duplex_uart_transaction_core.sv @@
`default_nettype none
// Single-wire half-duplex 8N1 UART transaction engine. Each request beat is a tick
// (one time unit, with the sampled line level), a load of one transmit byte, or a
// start of a transaction that sends all loaded bytes and then receives rx_len bytes.
// Every request beat yields exactly one response beat, computed combinationally and held
// in an output register; a new request is taken every cycle while that register is
// empty or being drained, so the sustained rate is one beat per clock. The transmit
// bytes sit in a one-port-read synchronous RAM of TX_DEPTH entries; the next byte is
// prefetched from it while the current one shifts out, with write forwarding for a
// start that directly follows a load. The RAM contents are undefined after reset and
// need no clearing pass, since only loaded entries are ever sent. Configuration
// writes are always accepted and must only be issued while the block is idle.
module half_duplex_uart_transaction_core
   import hdut_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire hdut_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output hdut_rsp_type      rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [23:0]  csr_data
);

   typedef enum logic [2:0] {
      PH_IDLE, PH_TX, PH_RXWAIT, PH_RXHALF, PH_RXBITS, PH_RXSTOP, PH_GAP
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [TX_CW-1:0]  tx_count_ff, tx_count_in;
   logic [TX_CW-1:0]  tx_index_ff, tx_index_in;
   logic [3:0]        bit_index_ff, bit_index_in;
   logic [TMR_W-1:0]  timer_ff, timer_in;
   logic [7:0]        shift_ff, shift_in;
   logic [7:0]        rx_target_ff, rx_target_in;
   logic [7:0]        rx_done_ff, rx_done_in;

   logic [15:0]       bit_time_ff;
   logic [15:0]       half_bit_ff;
   logic [TMR_W-1:0]  rx_timeout_ff;

   logic [7:0]        tx_mem [TX_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [TX_AW-1:0]  rd_addr;
   logic [TX_AW-1:0]  wr_addr;
   logic              wr_en;
   logic              fwd_hit_ff;
   logic [7:0]        fwd_data_ff;
   logic [7:0]        prefetch;

   logic              rsp_valid_ff;
   hdut_rsp_type      rsp_ff, rsp_in;

   logic              req_fire;
   logic [TMR_W-1:0]  t_inc;
   logic [3:0]        bi_inc;
   logic [TX_CW-1:0]  idx_inc;
   logic [GAP_TW-1:0] gap_ticks;
   logic              gap_zero;
   logic              ev_valid, ev_done;
   logic [7:0]        ev_byte;
   logic [1:0]        ev_status;
   logic              lo, drv;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign t_inc     = timer_ff + TMR_W'(1);
   assign bi_inc    = bit_index_ff + 4'd1;
   assign idx_inc   = tx_index_ff + TX_CW'(1);
   assign gap_ticks = GAP_TW'(GAP_BITS) * GAP_TW'(bit_time_ff);
   assign gap_zero  = (gap_ticks == '0);

   // next byte address: the following entry while sending, entry 0 otherwise
   assign rd_addr  = (phase_ff == PH_TX) ? TX_AW'(idx_inc) : '0;
   assign wr_addr  = TX_AW'(tx_count_ff);
   assign prefetch = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tx_mem[wr_addr] <= req_data.tx_byte;
      end
      rd_data_ff  <= tx_mem[rd_addr];
      fwd_data_ff <= req_data.tx_byte;
      fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
   end

   always_comb begin
      phase_in     = phase_ff;
      tx_count_in  = tx_count_ff;
      tx_index_in  = tx_index_ff;
      bit_index_in = bit_index_ff;
      timer_in     = timer_ff;
      shift_in     = shift_ff;
      rx_target_in = rx_target_ff;
      rx_done_in   = rx_done_ff;
      wr_en        = 1'b0;
      ev_valid     = 1'b0;
      ev_done      = 1'b0;
      ev_byte      = '0;
      ev_status    = ST_OK;
      if (req_fire) begin
         unique case (req_data.req_type)
            REQ_TICK: begin
               unique case (phase_ff)
                  PH_TX: begin
                     timer_in = t_inc;
                     if (t_inc >= TMR_W'(bit_time_ff)) begin
                        timer_in     = '0;
                        bit_index_in = bi_inc;
                        if (bi_inc > 4'd9) begin
                           bit_index_in = '0;
                           tx_index_in  = idx_inc;
                           if (idx_inc < tx_count_ff) begin
                              shift_in = prefetch;
                           end else if (rx_done_ff < rx_target_ff) begin
                              phase_in = PH_RXWAIT;
                           end else if (gap_zero) begin
                              phase_in    = PH_IDLE;
                              tx_count_in = '0;
                              tx_index_in = '0;
                              ev_done     = 1'b1;
                           end else begin
                              phase_in = PH_GAP;
                           end
                        end
                     end
                  end
                  PH_RXWAIT: begin
                     if (!req_data.line_in) begin
                        shift_in = '0;
                        timer_in = '0;
                        if (half_bit_ff == '0) begin
                           phase_in     = PH_RXBITS;
                           bit_index_in = '0;
                        end else begin
                           phase_in = PH_RXHALF;
                        end
                     end else if (timer_ff >= rx_timeout_ff) begin
                        phase_in     = PH_IDLE;
                        tx_count_in  = '0;
                        tx_index_in  = '0;
                        bit_index_in = '0;
                        timer_in     = '0;
                        ev_done      = 1'b1;
                        ev_status    = ST_TIMEOUT;
                     end else begin
                        timer_in = t_inc;
                     end
                  end
                  PH_RXHALF: begin
                     timer_in = t_inc;
                     if (t_inc >= TMR_W'(half_bit_ff)) begin
                        phase_in     = PH_RXBITS;
                        bit_index_in = '0;
                        timer_in     = '0;
                     end
                  end
                  PH_RXBITS: begin
                     timer_in = t_inc;
                     if (t_inc >= TMR_W'(bit_time_ff)) begin
                        timer_in     = '0;
                        shift_in     = shift_ff
                                     | (8'(req_data.line_in) << bit_index_ff[2:0]);
                        bit_index_in = bi_inc;
                        if (bi_inc >= 4'd8) begin
                           bit_index_in = '0;
                           ev_valid     = 1'b1;
                           ev_byte      = shift_in;
                           rx_done_in   = rx_done_ff + 8'd1;
                           phase_in     = PH_RXSTOP;
                        end
                     end
                  end
                  PH_RXSTOP: begin
                     timer_in = t_inc;
                     if (t_inc >= TMR_W'(bit_time_ff)) begin
                        timer_in = '0;
                        if (rx_done_ff < rx_target_ff) begin
                           phase_in = PH_RXWAIT;
                        end else if (gap_zero) begin
                           phase_in     = PH_IDLE;
                           tx_count_in  = '0;
                           tx_index_in  = '0;
                           bit_index_in = '0;
                           ev_done      = 1'b1;
                        end else begin
                           phase_in = PH_GAP;
                        end
                     end
                  end
                  PH_GAP: begin
                     timer_in = t_inc;
                     if (t_inc >= TMR_W'(gap_ticks)) begin
                        phase_in     = PH_IDLE;
                        tx_count_in  = '0;
                        tx_index_in  = '0;
                        bit_index_in = '0;
                        timer_in     = '0;
                        ev_done      = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            REQ_LOAD: begin
               if (phase_ff == PH_IDLE && tx_count_ff < TX_CW'(TX_DEPTH)) begin
                  wr_en       = 1'b1;
                  tx_count_in = tx_count_ff + TX_CW'(1);
               end else begin
                  ev_status = ST_IGNORED;
               end
            end
            REQ_START: begin
               if (phase_ff == PH_IDLE) begin
                  rx_target_in = req_data.rx_len;
                  rx_done_in   = '0;
                  tx_index_in  = '0;
                  bit_index_in = '0;
                  timer_in     = '0;
                  if (tx_count_ff != '0) begin
                     shift_in = prefetch;
                     phase_in = PH_TX;
                  end else if (req_data.rx_len != '0) begin
                     phase_in = PH_RXWAIT;
                  end else if (gap_zero) begin
                     tx_count_in = '0;
                     ev_done     = 1'b1;
                  end else begin
                     phase_in = PH_GAP;
                  end
               end else begin
                  ev_status = ST_IGNORED;
               end
            end
            default: ev_status = ST_IGNORED;
         endcase
      end

      lo  = 1'b1;
      drv = 1'b1;
      if (phase_in == PH_TX) begin
         if (bit_index_in == '0) begin
            lo = 1'b0;
         end else if (bit_index_in <= 4'd8) begin
            lo = shift_in[3'(bit_index_in - 4'd1)];
         end
      end else if (phase_in == PH_RXWAIT || phase_in == PH_RXHALF
                   || phase_in == PH_RXBITS || phase_in == PH_RXSTOP) begin
         drv = 1'b0;
      end

      rsp_in.line_out    = lo;
      rsp_in.line_drive  = drv;
      rsp_in.rx_byte     = ev_byte;
      rsp_in.rx_valid    = ev_valid;
      rsp_in.done_res    = ev_done;
      rsp_in.status      = ev_status;
      rsp_in.rx_received = rx_done_in;
      rsp_in.busy_res    = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tx_count_ff   <= '0;
         tx_index_ff   <= '0;
         bit_index_ff  <= '0;
         timer_ff      <= '0;
         shift_ff      <= '0;
         rx_target_ff  <= '0;
         rx_done_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         bit_time_ff   <= BIT_TIME_RST;
         half_bit_ff   <= HALF_BIT_RST;
         rx_timeout_ff <= RX_TIMEOUT_RST;
      end else begin
         phase_ff     <= phase_in;
         tx_count_ff  <= tx_count_in;
         tx_index_ff  <= tx_index_in;
         bit_index_ff <= bit_index_in;
         timer_ff     <= timer_in;
         shift_ff     <= shift_in;
         rx_target_ff <= rx_target_in;
         rx_done_ff   <= rx_done_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_BIT_TIME:   bit_time_ff   <= csr_data[15:0];
               CSR_HALF_BIT:   half_bit_ff   <= csr_data[15:0];
               CSR_RX_TIMEOUT: rx_timeout_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TX |-> tx_index_ff < tx_count_ff)
      else $error("sending past the loaded bytes");

   assert property (@(posedge clock) disable iff (reset)
      bit_index_ff <= 4'd9)
      else $error("bit counter out of range");

   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> phase_ff == PH_IDLE && tx_count_ff < TX_CW'(TX_DEPTH))
      else $error("buffer write outside idle or past depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.rx_valid |-> rsp_ff.busy_res && !rsp_ff.line_drive)
      else $error("received byte reported while not receiving");

   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_RXWAIT |-> timer_ff <= rx_timeout_ff)
      else $error("start bit wait ran past timeout");

endmodule
`default_nettype wire
